// ----- sv/alg_pkg.sv -----
// Shared constants and types for the audio loopback gain FIFO.
`timescale 1ns / 1ps

package alg_pkg;

    // Ring geometry.
    localparam int RING_FRAMES = 4096;
    localparam int PTR_W       = $clog2(RING_FRAMES);
    localparam int FILL_W      = $clog2(RING_FRAMES + 1);

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int PROD_W   = 32;
    localparam int FRAC_W   = 14;
    localparam int CFG_IDX_W = 2;

    // Register reset values.
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8192);

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_CH0 = 2'd0,
        CFG_GAIN_CH1 = 2'd1,
        CFG_PLAY_EN  = 2'd2
    } t_cfg_idx;

    // Pipeline control shared by the gain lanes.
    typedef struct packed {
        logic en_mul;   // product stage loads
        logic en_out;   // output stage loads
        logic hit_mul;  // product stage holds a frame from the ring
    } t_stage_ctl;

endpackage

// ----- sv/audio_loopback_gain_fifo.sv -----
// Top level of the stereo audio loopback FIFO with per-channel gain.
// A pull result passes through stage 1, stage 2 and the output register before it is valid.
// One request is accepted per cycle while the output is taken; a push causes no result.
// The ring RAM read, the gain multiply and the round/saturate step are the three stages.
// Synchronous active-low reset clears pointers, pipeline valids and registers;
// ring contents are undefined until written and need no clearing pass.
`timescale 1ns / 1ps

module audio_loopback_gain_fifo
    import alg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [GAIN_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_opcode,
    input  logic signed [SAMPLE_W-1:0] i_upper_sample,
    input  logic signed [SAMPLE_W-1:0] i_lower_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_out_channel0,
    output logic signed [SAMPLE_W-1:0] o_out_channel1,
    output logic                       o_from_buffer
);

    logic [GAIN_W-1:0] r_gain0, r_gain1;
    logic              r_play;
    logic              r_s1_v, r_s1_hit;
    logic              r_s2_v, r_s2_hit;
    logic              r_out_v, r_out_hit;
    logic              w_en1, w_en2, w_en3;
    logic              w_accept, w_push, w_pull, w_pop;
    logic [PTR_W-1:0]  w_wr_ptr, w_rd_ptr;
    logic              w_not_empty;
    logic [FRAME_W-1:0] w_rdata;
    t_stage_ctl        w_ctl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain0 <= GAIN_RESET;
            r_gain1 <= GAIN_RESET;
            r_play  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_CH0: r_gain0 <= i_cfg_data;
                CFG_GAIN_CH1: r_gain1 <= i_cfg_data;
                CFG_PLAY_EN:  r_play  <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its content moves on.
    assign w_en3 = !r_out_v || i_out_ready;
    assign w_en2 = !r_s2_v || w_en3;
    assign w_en1 = !r_s1_v || w_en2;

    assign o_in_ready = w_en1;
    assign w_accept   = i_in_valid && w_en1;
    assign w_push     = w_accept && (i_opcode == OP_PUSH);
    assign w_pull     = w_accept && (i_opcode == OP_PULL);
    assign w_pop      = w_pull && r_play && w_not_empty;

    // Ring pointers and fill count.
    alg_ring_ctrl u_ring_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop       (w_pop),
        .o_wr_ptr    (w_wr_ptr),
        .o_rd_ptr    (w_rd_ptr),
        .o_not_empty (w_not_empty)
    );

    // Frame storage: upper sample in the high half.
    alg_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (RING_FRAMES)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (w_wr_ptr),
        .i_wdata ({i_upper_sample, i_lower_sample}),
        .i_re    (w_pop),
        .i_raddr (w_rd_ptr),
        .o_rdata (w_rdata)
    );

    // Pipeline valid and hit flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_v <= w_pull;
            end
            if (w_en2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_en3) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_hit <= w_pop;
        end
        if (w_en2) begin
            r_s2_hit <= r_s1_hit;
        end
        if (w_en3) begin
            r_out_hit <= r_s2_hit;
        end
    end

    assign w_ctl.en_mul  = w_en2;
    assign w_ctl.en_out  = w_en3;
    assign w_ctl.hit_mul = r_s2_hit;

    // Gain lanes: channel 0 takes the upper half.
    alg_gain_lane u_lane0 (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (w_rdata[FRAME_W-1:SAMPLE_W]),
        .i_gain   (r_gain0),
        .o_sample (o_out_channel0)
    );

    alg_gain_lane u_lane1 (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (w_rdata[SAMPLE_W-1:0]),
        .i_gain   (r_gain1),
        .o_sample (o_out_channel1)
    );

    assign o_out_valid   = r_out_v;
    assign o_from_buffer = r_out_hit;

endmodule

// ----- sv/alg_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module alg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/alg_ring_ctrl.sv -----
// Write pointer, read pointer and fill count of the frame ring.
`timescale 1ns / 1ps

module alg_ring_ctrl
    import alg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_pop,
    output logic [PTR_W-1:0] o_wr_ptr,
    output logic [PTR_W-1:0] o_rd_ptr,
    output logic             o_not_empty
);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_FRAMES - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_FRAMES);

    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              w_full;
    logic [PTR_W-1:0]  w_wr_inc, w_rd_inc;

    assign w_full   = (r_fill == FILL_MAX);
    assign w_wr_inc = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
    assign w_rd_inc = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);

    // A push into a full ring drops the oldest frame; a pop frees one.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = w_wr_inc;
            if (w_full) begin
                n_rd_ptr = w_rd_inc;
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end else if (i_pop) begin
            n_rd_ptr = w_rd_inc;
            n_fill   = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    assign o_wr_ptr    = r_wr_ptr;
    assign o_rd_ptr    = r_rd_ptr;
    assign o_not_empty = (r_fill != '0);

endmodule

// ----- sv/alg_gain_lane.sv -----
// One channel of gain: multiply, then round half to even and saturate; a frame not from the ring gives zero.
`timescale 1ns / 1ps

module alg_gain_lane
    import alg_pkg::*;
(
    input  logic                       i_clk,
    input  t_stage_ctl                 i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [GAIN_W-1:0]   i_gain,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int Q_W = PROD_W - FRAC_W + 1;
    localparam logic [FRAC_W-1:0] HALF = FRAC_W'(1) << (FRAC_W - 1);
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [Q_W-1:0]      w_floor;
    logic signed [Q_W-1:0]      w_round;
    logic        [FRAC_W-1:0]   w_rem;
    logic                       w_up;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic signed [SAMPLE_W-1:0] r_sample;

    // Product stage: signed sample times unsigned gain.
    assign w_prod = PROD_W'(i_sample) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_prod <= w_prod;
        end
    end

    // Round to nearest with ties to even, then clamp to 16 bits.
    assign w_floor = Q_W'($signed(r_prod[PROD_W-1:FRAC_W]));
    assign w_rem   = r_prod[FRAC_W-1:0];
    assign w_up    = (w_rem > HALF) || ((w_rem == HALF) && w_floor[0]);
    assign w_round = w_floor + Q_W'(w_up);

    always_comb begin
        if (!i_ctl.hit_mul) begin
            n_sample = '0;
        end else if (w_round > Q_MAX) begin
            n_sample = SAMPLE_W'(Q_MAX);
        end else if (w_round < Q_MIN) begin
            n_sample = SAMPLE_W'(Q_MIN);
        end else begin
            n_sample = SAMPLE_W'(w_round);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule
